// File: design/slq_pkg.sv
// shared types and constants of the shared/exclusive lock queue
package slq_pkg;

	localparam int NUM_SLOTS_DEF   = 64;
	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int TXN_BITS_DEF    = 8;
	localparam int MAX_RESULTS     = 8;
	localparam int TXN_W           = 8;
	localparam int RES_W           = 6;

	typedef enum logic [1:0] {
		REQ_SHARED    = 2'd0,
		REQ_EXCLUSIVE = 2'd1,
		REQ_UNLOCK    = 2'd2,
		REQ_CANCEL    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_GRANTED   = 3'd0,
		ST_WAITING   = 3'd1,
		ST_HELD      = 3'd2,
		ST_RELEASED  = 3'd3,
		ST_NOT_HELD  = 3'd4,
		ST_FULL      = 3'd5,
		ST_CANCELLED = 3'd6,
		ST_NONE      = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEN_RD,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic             vld;
		logic [TXN_W-1:0] txn;
		logic [RES_W-1:0] res;
		status_t          status;
		logic             mode;
	} res_t;

endpackage

// File: design/slq_ram.sv
// generic single write port ram with registered read
module slq_ram #(
	parameter int WIDTH = 8,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [(1 << AW)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/slq_out.sv
// result stage: holds one word back so the final word can carry last
module slq_out (
	input  logic                      clk,
	input  logic                      arst_n,
	input  slq_pkg::res_t             gen,
	input  logic                      flush,
	output logic                      strobe,
	output logic [slq_pkg::TXN_W-1:0] out_txn,
	output logic [slq_pkg::RES_W-1:0] out_resource,
	output logic [2:0]                status,
	output logic                      granted_mode,
	output logic                      last
);

	slq_pkg::res_t pend_q;
	logic          strobe_q;
	slq_pkg::res_t word_q;
	logic          last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q.vld <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (gen.vld) begin
				if (pend_q.vld) begin
					strobe_q <= 1'b1;
					word_q   <= pend_q;
					last_q   <= 1'b0;
				end
				pend_q <= gen;
			end else if (flush && pend_q.vld) begin
				strobe_q   <= 1'b1;
				word_q     <= pend_q;
				last_q     <= 1'b1;
				pend_q.vld <= 1'b0;
			end
		end
	end

	assign strobe       = strobe_q;
	assign out_txn      = word_q.txn;
	assign out_resource = word_q.res;
	assign status       = word_q.status;
	assign granted_mode = word_q.mode;
	assign last         = last_q;

endmodule

// File: design/shared_exclusive_lock_queue.sv
// top level: shared/exclusive lock queues per resource slot, held in ram
// an item steps through length read, scan of any queued entries, decide, compaction after a
// removal from a longer queue, and flush; a slot off the table goes from length read to flush
// one entry ram access per cycle in scan and compaction
// busy stays high for the whole item; results cannot be stalled
// reset clears the queue lengths through per-slot valid bits, no clearing pass
module shared_exclusive_lock_queue #(
	parameter int NUM_SLOTS   = slq_pkg::NUM_SLOTS_DEF,
	parameter int QUEUE_DEPTH = slq_pkg::QUEUE_DEPTH_DEF,
	parameter int TXN_BITS    = slq_pkg::TXN_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                req_type,
	input  logic [slq_pkg::TXN_W-1:0] txn_id,
	input  logic [slq_pkg::RES_W-1:0] resource,
	output logic                      strobe,
	output logic [slq_pkg::TXN_W-1:0] out_txn,
	output logic [slq_pkg::RES_W-1:0] out_resource,
	output logic [2:0]                status,
	output logic                      granted_mode,
	output logic                      last
);

	// only 64 slots are reachable through the resource field
	localparam int SLOTS     = (NUM_SLOTS < 64) ? NUM_SLOTS : 64;
	localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IDX_BITS  = $clog2(QUEUE_DEPTH);
	localparam int LEN_BITS  = $clog2(QUEUE_DEPTH + 1);
	localparam int ENT_W     = TXN_BITS + 2;

	slq_pkg::state_t state_q, state_d;
	slq_pkg::req_t   type_q;
	logic [TXN_BITS-1:0]       txn_q;
	logic [slq_pkg::RES_W-1:0] res_q;
	logic [LEN_BITS-1:0]       len_q, rcnt_q, dcnt_q, fidx_q;
	logic                      found_q, fmode_q, any_excl_q, all_same_q;
	logic [TXN_BITS-1:0]       first_txn_q;
	logic                      allfirst_q, excl_b_q;
	logic [2:0]                ngr_q;
	logic [SLOTS-1:0]          vld_q;

	// ram ports
	logic                      len_we;
	logic [SLOT_BITS-1:0]      len_raddr;
	logic [LEN_BITS-1:0]       len_wdata, len_rdata;
	logic                      ent_we;
	logic [IDX_BITS-1:0]       ent_widx, ent_ridx;
	logic [ENT_W-1:0]          ent_wdata, ent_rdata;

	logic [SLOT_BITS-1:0]      slot;
	logic [TXN_BITS-1:0]       e_txn;
	logic                      e_mode, e_gr;
	logic [LEN_BITS-1:0]       len_now, rd_src;
	logic                      match, grant_now, in_range_q;
	slq_pkg::res_t             gen;
	logic                      flush;

	assign slot   = res_q[SLOT_BITS-1:0];
	assign e_txn  = ent_rdata[ENT_W-1:2];
	assign e_mode = ent_rdata[1];
	assign e_gr   = ent_rdata[0];
	assign len_now = vld_q[slot] ? len_rdata : '0;
	assign in_range_q = 32'(res_q) < NUM_SLOTS;

	// first entry of the transaction; cancel only looks at waiting entries
	assign match = (e_txn == txn_q) && ((type_q != slq_pkg::REQ_CANCEL) || !e_gr);

	// compaction: shared waits on any exclusive ahead, exclusive on any other txn ahead
	always_comb begin
		logic can;
		can = e_mode ? ((dcnt_q == '0) || (allfirst_q && (first_txn_q == e_txn)))
		             : !excl_b_q;
		grant_now = !e_gr && can && (ngr_q < 3'(slq_pkg::MAX_RESULTS - 1));
	end

	always_comb begin
		state_d    = state_q;
		busy       = (state_q != slq_pkg::S_IDLE);
		len_raddr  = (state_q == slq_pkg::S_IDLE) ? resource[SLOT_BITS-1:0] : slot;
		len_we     = 1'b0;
		len_wdata  = len_q - LEN_BITS'(1);
		ent_we     = 1'b0;
		ent_widx   = len_q[IDX_BITS-1:0];
		ent_wdata  = {txn_q, type_q[0], 1'b0};
		rd_src     = rcnt_q;
		gen        = '0;
		gen.txn    = slq_pkg::TXN_W'(txn_q);
		gen.res    = res_q;
		flush      = 1'b0;
		case (state_q)
			slq_pkg::S_IDLE: begin
				if (start) begin
					state_d = slq_pkg::S_LEN_RD;
				end
			end
			slq_pkg::S_LEN_RD: begin
				if (!in_range_q) begin
					// slot beyond the table: answer and change nothing
					gen.vld = 1'b1;
					gen.mode = (type_q == slq_pkg::REQ_EXCLUSIVE);
					case (type_q)
						slq_pkg::REQ_UNLOCK: gen.status = slq_pkg::ST_NOT_HELD;
						slq_pkg::REQ_CANCEL: gen.status = slq_pkg::ST_NONE;
						default:             gen.status = slq_pkg::ST_FULL;
					endcase
					state_d = slq_pkg::S_FLUSH;
				end else begin
					rd_src  = '0;
					state_d = (len_now == '0) ? slq_pkg::S_DECIDE : slq_pkg::S_SCAN;
				end
			end
			slq_pkg::S_SCAN: begin
				if (dcnt_q == len_q - LEN_BITS'(1)) begin
					state_d = slq_pkg::S_DECIDE;
				end
			end
			slq_pkg::S_DECIDE: begin
				gen.vld = 1'b1;
				state_d = slq_pkg::S_FLUSH;
				if (type_q == slq_pkg::REQ_SHARED || type_q == slq_pkg::REQ_EXCLUSIVE) begin
					if (found_q && (type_q == slq_pkg::REQ_SHARED || fmode_q)) begin
						gen.status = slq_pkg::ST_HELD;
						gen.mode   = fmode_q;
					end else if (32'(len_q) >= QUEUE_DEPTH) begin
						gen.status = slq_pkg::ST_FULL;
						gen.mode   = type_q[0];
					end else begin
						// append, granted at once when nothing ahead blocks it
						ent_we    = 1'b1;
						ent_wdata = {txn_q, type_q[0],
						             type_q[0] ? all_same_q : !any_excl_q};
						len_we    = 1'b1;
						len_wdata = len_q + LEN_BITS'(1);
						gen.mode  = type_q[0];
						gen.status = (type_q[0] ? all_same_q : !any_excl_q) ?
						             slq_pkg::ST_GRANTED : slq_pkg::ST_WAITING;
					end
				end else if (!found_q) begin
					gen.status = (type_q == slq_pkg::REQ_UNLOCK) ?
					             slq_pkg::ST_NOT_HELD : slq_pkg::ST_NONE;
				end else begin
					len_we     = 1'b1;
					gen.mode   = fmode_q;
					gen.status = (type_q == slq_pkg::REQ_UNLOCK) ?
					             slq_pkg::ST_RELEASED : slq_pkg::ST_CANCELLED;
					rd_src     = (fidx_q == '0) ? LEN_BITS'(1) : '0;
					if (len_q != LEN_BITS'(1)) begin
						state_d = slq_pkg::S_SHIFT;
					end
				end
			end
			slq_pkg::S_SHIFT: begin
				// move entries down over the removed one and wake waiters
				rd_src    = (rcnt_q < fidx_q) ? rcnt_q : rcnt_q + LEN_BITS'(1);
				ent_we    = 1'b1;
				ent_widx  = dcnt_q[IDX_BITS-1:0];
				ent_wdata = {e_txn, e_mode, e_gr | grant_now};
				if (grant_now) begin
					gen.vld    = 1'b1;
					gen.txn    = slq_pkg::TXN_W'(e_txn);
					gen.status = slq_pkg::ST_GRANTED;
					gen.mode   = e_mode;
				end
				if (dcnt_q == len_q - LEN_BITS'(2)) begin
					state_d = slq_pkg::S_FLUSH;
				end
			end
			slq_pkg::S_FLUSH: begin
				flush   = 1'b1;
				state_d = slq_pkg::S_IDLE;
			end
			default: begin
				state_d = slq_pkg::S_IDLE;
			end
		endcase
		ent_ridx = rd_src[IDX_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slq_pkg::S_IDLE;
			vld_q   <= '0;
		end else begin
			state_q <= state_d;
			if (len_we) begin
				vld_q[slot] <= 1'b1;
			end
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			slq_pkg::S_IDLE: begin
				type_q <= slq_pkg::req_t'(req_type);
				txn_q  <= TXN_BITS'(txn_id);
				res_q  <= resource;
			end
			slq_pkg::S_LEN_RD: begin
				len_q      <= len_now;
				rcnt_q     <= LEN_BITS'(1);
				dcnt_q     <= '0;
				found_q    <= 1'b0;
				any_excl_q <= 1'b0;
				all_same_q <= 1'b1;
			end
			slq_pkg::S_SCAN: begin
				if (match && !found_q) begin
					found_q <= 1'b1;
					fidx_q  <= dcnt_q;
					fmode_q <= e_mode;
				end
				any_excl_q <= any_excl_q | e_mode;
				all_same_q <= all_same_q & (e_txn == txn_q);
				dcnt_q     <= dcnt_q + LEN_BITS'(1);
				rcnt_q     <= rcnt_q + LEN_BITS'(1);
			end
			slq_pkg::S_DECIDE: begin
				rcnt_q     <= LEN_BITS'(1);
				dcnt_q     <= '0;
				allfirst_q <= 1'b1;
				excl_b_q   <= 1'b0;
				ngr_q      <= '0;
			end
			slq_pkg::S_SHIFT: begin
				if (dcnt_q == '0) begin
					first_txn_q <= e_txn;
				end else begin
					allfirst_q <= allfirst_q & (e_txn == first_txn_q);
				end
				excl_b_q <= excl_b_q | e_mode;
				if (grant_now) begin
					ngr_q <= ngr_q + 3'd1;
				end
				dcnt_q <= dcnt_q + LEN_BITS'(1);
				rcnt_q <= rcnt_q + LEN_BITS'(1);
			end
			default: begin
			end
		endcase
	end

	slq_ram #(.WIDTH(LEN_BITS), .AW(SLOT_BITS)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (slot),
		.wdata (len_wdata),
		.raddr (len_raddr),
		.rdata (len_rdata)
	);

	slq_ram #(.WIDTH(ENT_W), .AW(SLOT_BITS + IDX_BITS)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr ({slot, ent_widx}),
		.wdata (ent_wdata),
		.raddr ({slot, ent_ridx}),
		.rdata (ent_rdata)
	);

	slq_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.gen          (gen),
		.flush        (flush),
		.strobe       (strobe),
		.out_txn      (out_txn),
		.out_resource (out_resource),
		.status       (status),
		.granted_mode (granted_mode),
		.last         (last)
	);

endmodule

// File: sim/tb.sv
// testbench for the shared/exclusive lock queue: directed table, random traffic, predictor check
module tb;
	import slq_pkg::*;

	localparam int SLOTS = 64;
	localparam int DEPTH = 8;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        req_type;
	logic [TXN_W-1:0]  txn_id;
	logic [RES_W-1:0]  resource;
	logic              strobe;
	logic [TXN_W-1:0]  out_txn;
	logic [RES_W-1:0]  out_resource;
	logic [2:0]        status;
	logic              granted_mode;
	logic              last;

	shared_exclusive_lock_queue u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .txn_id(txn_id), .resource(resource),
		.strobe(strobe), .out_txn(out_txn), .out_resource(out_resource),
		.status(status), .granted_mode(granted_mode), .last(last)
	);

	// one word on the result side
	typedef struct packed {
		logic [TXN_W-1:0] txn;
		logic [RES_W-1:0] res;
		logic [2:0]       st;
		logic             mode;
		logic             lst;
	} word_t;

	// one lock queue entry as the predictor keeps it
	typedef struct packed {
		logic [TXN_W-1:0] txn;
		logic             mode;
		logic             granted;
	} lock_t;

	// directed row: typed-in answer only where chk is set
	typedef struct packed {
		req_t             op;
		logic [TXN_W-1:0] txn;
		logic [RES_W-1:0] res;
		logic             chk;
		logic [2:0]       st;
		logic             mode;
	} row_t;

	lock_t  lock_q [SLOTS][DEPTH];
	int     lock_len [SLOTS];
	word_t  pending_words [$];
	int     errors;
	int     send_idle_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// generous fixed limit: 480 items at the slowest pace with long gaps
	initial begin
		#4000000;
		$display("status: fail");
		$finish;
	end

	// shared entry waits behind any exclusive; exclusive needs only its own txn ahead
	function automatic bit lock_grantable(int s, int p);
		for (int i = 0; i < p; i++) begin
			if (lock_q[s][p].mode) begin
				if (lock_q[s][i].txn != lock_q[s][p].txn) return 0;
			end else if (lock_q[s][i].mode) begin
				return 0;
			end
		end
		return 1;
	endfunction

	function automatic void push_word(logic [TXN_W-1:0] t, int s, status_t st, logic m);
		word_t w;
		w.txn = t;
		w.res = s[RES_W-1:0];
		w.st = st;
		w.mode = m;
		w.lst = 1'b0;
		pending_words.insert(pending_words.size(), w);
	endfunction

	// work out the words of one accepted request and update the queue copy
	function automatic void predict_lock(req_t op, logic [TXN_W-1:0] t, int s);
		int held;
		int found;
		int n;
		logic m;
		held = -1;
		found = -1;
		n = 1;
		if (op == REQ_SHARED || op == REQ_EXCLUSIVE) begin
			m = (op == REQ_EXCLUSIVE);
			for (int i = 0; i < lock_len[s]; i++)
				if (held < 0 && lock_q[s][i].txn == t) held = i;
			if (held >= 0 && (!m || lock_q[s][held].mode)) begin
				push_word(t, s, ST_HELD, lock_q[s][held].mode);
			end else if (lock_len[s] >= DEPTH) begin
				push_word(t, s, ST_FULL, m);
			end else begin
				lock_q[s][lock_len[s]] = '{txn: t, mode: m, granted: 1'b0};
				lock_len[s]++;
				if (lock_grantable(s, lock_len[s] - 1)) begin
					lock_q[s][lock_len[s] - 1].granted = 1'b1;
					push_word(t, s, ST_GRANTED, m);
				end else begin
					push_word(t, s, ST_WAITING, m);
				end
			end
		end else begin
			for (int i = 0; i < lock_len[s]; i++)
				if (found < 0 && lock_q[s][i].txn == t &&
				    (op == REQ_UNLOCK || !lock_q[s][i].granted)) found = i;
			if (found < 0) begin
				push_word(t, s, (op == REQ_UNLOCK) ? ST_NOT_HELD : ST_NONE, 1'b0);
			end else begin
				m = lock_q[s][found].mode;
				for (int i = found; i + 1 < lock_len[s]; i++)
					lock_q[s][i] = lock_q[s][i + 1];
				lock_len[s]--;
				push_word(t, s, (op == REQ_UNLOCK) ? ST_RELEASED : ST_CANCELLED, m);
				// wake released waiters in queue order, bounded by the notice limit
				for (int i = 0; i < lock_len[s] && n < MAX_RESULTS; i++) begin
					if (!lock_q[s][i].granted && lock_grantable(s, i)) begin
						lock_q[s][i].granted = 1'b1;
						push_word(lock_q[s][i].txn, s, ST_GRANTED, lock_q[s][i].mode);
						n++;
					end
				end
			end
		end
		pending_words[pending_words.size() - 1].lst = 1'b1;
	endfunction

	// drive one request and hold it until the block takes it
	task automatic send_req(req_t op, logic [TXN_W-1:0] t, logic [RES_W-1:0] s);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= op;
		txn_id <= t;
		resource <= s;
		do @(posedge clk); while (busy);
		predict_lock(op, t, s);
	endtask

	// compare every strobed word with the oldest expectation
	always @(posedge clk) begin
		word_t got;
		word_t want;
		if (arst_n && strobe) begin
			got = '{txn: out_txn, res: out_resource, st: status,
				mode: granted_mode, lst: last};
			if (pending_words.size() == 0) begin
				$display("%0t unexpected word: got %h", $time, got);
				errors++;
			end else begin
				want = pending_words.pop_front();
				if (got.txn != want.txn)
					$display("%0t out_txn: expected %0d actual %0d", $time, want.txn, got.txn);
				if (got.res != want.res)
					$display("%0t out_resource: expected %0d actual %0d", $time, want.res,
						got.res);
				if (got.st != want.st)
					$display("%0t status: expected %0d actual %0d", $time, want.st, got.st);
				if (got.mode != want.mode)
					$display("%0t granted_mode: expected %0d actual %0d", $time, want.mode,
						got.mode);
				if (got.lst != want.lst)
					$display("%0t last: expected %0d actual %0d", $time, want.lst, got.lst);
				if (got != want) errors++;
			end
		end
	end

	// random item: mostly a few txns on a few hot slots so queues fill and wake
	task automatic random_item();
		req_t op;
		logic [TXN_W-1:0] t;
		logic [RES_W-1:0] s;
		op = req_t'($urandom_range(3));
		if ($urandom_range(9) < 8) begin
			s = $urandom_range(3) == 0 ? 6'd63 : RES_W'($urandom_range(3));
			t = TXN_W'($urandom_range(11)) | ($urandom_range(1) ? 8'hf0 : 8'h00);
		end else begin
			s = RES_W'($urandom);
			t = TXN_W'($urandom);
		end
		send_req(op, t, s);
	endtask

	row_t rows [] = '{
		// after reset everything is empty
		'{REQ_UNLOCK,    8'h00, 6'd0,  1'b1, ST_NOT_HELD, 1'b0},
		'{REQ_CANCEL,    8'hff, 6'd63, 1'b1, ST_NONE,     1'b0},
		'{REQ_SHARED,    8'h01, 6'd5,  1'b1, ST_GRANTED,  1'b0},
		'{REQ_SHARED,    8'h02, 6'd5,  1'b1, ST_GRANTED,  1'b0},
		// repeat acquire is already held
		'{REQ_SHARED,    8'h01, 6'd5,  1'b1, ST_HELD,     1'b0},
		// upgrade queues behind the other shared holder
		'{REQ_EXCLUSIVE, 8'h01, 6'd5,  1'b0, 3'd0,        1'b0},
		'{REQ_EXCLUSIVE, 8'hff, 6'd5,  1'b0, 3'd0,        1'b0},
		'{REQ_SHARED,    8'h80, 6'd5,  1'b0, 3'd0,        1'b0},
		'{REQ_CANCEL,    8'hff, 6'd5,  1'b0, 3'd0,        1'b0},
		// unlock of the other shared holder wakes the upgrade
		'{REQ_UNLOCK,    8'h02, 6'd5,  1'b0, 3'd0,        1'b0},
		'{REQ_UNLOCK,    8'h01, 6'd5,  1'b0, 3'd0,        1'b0},
		'{REQ_UNLOCK,    8'h01, 6'd5,  1'b0, 3'd0,        1'b0},
		'{REQ_UNLOCK,    8'h80, 6'd5,  1'b0, 3'd0,        1'b0},
		// fill slot 63 behind an exclusive holder, then overflow it
		'{REQ_EXCLUSIVE, 8'h10, 6'd63, 1'b1, ST_GRANTED,  1'b1},
		'{REQ_EXCLUSIVE, 8'h11, 6'd63, 1'b1, ST_WAITING,  1'b1},
		'{REQ_SHARED,    8'h12, 6'd63, 1'b1, ST_WAITING,  1'b0},
		'{REQ_SHARED,    8'h13, 6'd63, 1'b1, ST_WAITING,  1'b0},
		'{REQ_SHARED,    8'h14, 6'd63, 1'b1, ST_WAITING,  1'b0},
		'{REQ_SHARED,    8'h15, 6'd63, 1'b1, ST_WAITING,  1'b0},
		'{REQ_SHARED,    8'h16, 6'd63, 1'b1, ST_WAITING,  1'b0},
		'{REQ_SHARED,    8'h17, 6'd63, 1'b1, ST_WAITING,  1'b0},
		'{REQ_SHARED,    8'h18, 6'd63, 1'b1, ST_FULL,     1'b0},
		// cancelling the exclusive waiter wakes nothing (head still exclusive)
		'{REQ_CANCEL,    8'h11, 6'd63, 1'b1, ST_CANCELLED, 1'b1},
		// release of the head wakes every shared waiter
		'{REQ_UNLOCK,    8'h10, 6'd63, 1'b0, 3'd0,        1'b0}
	};

	initial begin
		word_t w;
		errors = 0;
		send_idle_pct = 29;
		start = 1'b0;
		req_type = REQ_SHARED;
		txn_id = '0;
		resource = '0;
		for (int s = 0; s < SLOTS; s++) lock_len[s] = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			send_req(rows[i].op, rows[i].txn, rows[i].res);
			// typed-in answer must agree with what the predictor queued
			if (rows[i].chk) begin
				w = pending_words[$];
				for (int k = pending_words.size() - 1; k >= 0; k--)
					if (k == 0 || pending_words[k - 1].lst) begin
						w = pending_words[k];
						break;
					end
				if (w.st != rows[i].st || w.mode != rows[i].mode) begin
					$display("%0t row %0d: expected %0d/%0d actual %0d/%0d", $time, i,
						rows[i].st, rows[i].mode, w.st, w.mode);
					errors++;
				end
			end
		end

		// sender idles at 29 then 63 percent, then not at all
		for (int i = 0; i < 480; i++) begin
			send_idle_pct = (i < 160) ? 29 : (i < 320) ? 63 : 0;
			random_item();
		end
		start <= 1'b0;

		while (pending_words.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: sim.f
design/slq_pkg.sv
design/slq_ram.sv
design/slq_out.sv
design/shared_exclusive_lock_queue.sv
sim/tb.sv
